>>> sv/ssr_pkg.sv
// Shared types and constants for the stream search-and-replace block.
// No dependencies; imported by ssr_out_stage, stream_search_and_replace and ssr_checker.
`default_nettype none

package ssr_pkg;

    // Longest pattern the block is built for, and the register byte count
    localparam int SSR_MAX_PATTERN = 8;
    localparam int SSR_REG_BYTES   = 8;
    localparam int SSR_CFG_IDX_W   = 2;

    // Configuration register indexes
    typedef enum logic [SSR_CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    // Sequencer to output stage: one byte to emit, or close the current run
    typedef struct packed {
        logic       emit;
        logic       close;
        logic [7:0] data;
    } ostage_req_t;

    // Output stage to sequencer
    typedef struct packed {
        logic emit_ok;
        logic close_ok;
    } ostage_sts_t;

endpackage

`default_nettype wire

>>> sv/ssr_cell.sv
// One cell of the pending-byte row: holds a byte, compares it with its
// pattern byte and shifts toward the oldest end. No package dependency.
`default_nettype none

module ssr_cell
(
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire logic       load,
    input  wire logic [7:0] load_byte,
    input  wire logic [7:0] next_byte,
    input  wire logic [7:0] pat_byte,
    output logic      [7:0] data,
    output logic            match
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // shift takes the younger neighbor's byte; load appends a new byte
    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = next_byte;
        end
        else if (load)
        begin
            data_next = load_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == pat_byte);

endmodule

`default_nettype wire

>>> sv/ssr_out_stage.sv
// Output side: a hold register that keeps the latest byte until it is known
// whether more follow, then the registered master stream. Uses ssr_pkg.
`default_nettype none

module ssr_out_stage
    import ssr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ostage_req_t req,
    output ostage_sts_t      sts,
    output logic             out_tvalid,
    input  wire logic        out_tready,
    output logic       [7:0] out_tdata,   // [7:0] out_byte
    output logic             out_tlast    // last_of_run
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] hold_data_reg;
    logic [7:0] hold_data_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       can_push;
    logic       push;

    assign can_push     = !out_valid_reg || out_tready;
    assign sts.emit_ok  = !hold_valid_reg || can_push;
    assign sts.close_ok = !hold_valid_reg || can_push;
    assign push         = hold_valid_reg && can_push && (req.emit || req.close);

    // Held byte moves out when a newer byte arrives or the run closes
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = hold_data_reg;
            out_last_next  = req.close;
        end
        else if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (req.emit && sts.emit_ok)
        begin
            hold_valid_next = 1'b1;
            hold_data_next  = req.data;
        end
        else if (req.close && push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;
    assign out_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> sv/stream_search_and_replace.sv
// Stream search-and-replace: bytes in, bytes out, each occurrence of the
// configured pattern replaced by the configured string.
// Channels: slave stream in_* (tdata = byte, tlast = end of stream), master
// stream out_* (tdata = byte, tlast = last byte caused by one input beat),
// and a config write channel cfg_* (index 0 pattern bytes, 1 pattern length,
// 2 replacement bytes, 3 replacement length), always ready; write it only
// while the block is idle.
// One input beat is taken at a time. A beat passes the sequencer through
// scan, which releases bytes that can no longer start a match, then replace
// on a full pattern match or flush when tlast is set without one, then done,
// which closes the run. The sequencer moves one byte per cycle through the
// cell row or the replacement mux while the output stage accepts it. A
// released byte waits in a hold register until the next one (or the end of
// the run) is known, then moves to the output register that drives out_tdata.
// Reset empties the pending row and both output registers and loads the
// config defaults (pattern length 1, replacement length 0, zero bytes).
// A stalled receiver stops the sequencer at its next release; in_tready
// stays low until the run is fully handed to the output register.
`default_nettype none

module stream_search_and_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN = SSR_MAX_PATTERN
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_tvalid,
    output logic                          in_tready,
    input  wire logic               [7:0] in_tdata,   // [7:0] in_byte
    input  wire logic                     in_tlast,   // end_of_stream
    output logic                          out_tvalid,
    input  wire logic                     out_tready,
    output logic                    [7:0] out_tdata,  // [7:0] out_byte
    output logic                          out_tlast,  // last_of_run
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [SSR_CFG_IDX_W-1:0] cfg_index,
    input  wire logic              [63:0] cfg_data
);

    localparam int CAP   = (MAX_PATTERN < SSR_REG_BYTES) ? MAX_PATTERN : SSR_REG_BYTES;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam logic [3:0] CAP4 = 4'(CAP);
    localparam logic [3:0] RMAX = 4'(SSR_REG_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_REPL  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [2:0]        rep_idx_reg;
    logic [2:0]        rep_idx_next;
    logic              eos_reg;
    logic              eos_next;
    logic [63:0]       pattern_bytes_reg;
    logic [3:0]        pattern_length_reg;
    logic [63:0]       replacement_bytes_reg;
    logic [3:0]        replacement_length_reg;

    logic [3:0]        len_min1;
    logic [3:0]        len_eff;
    logic [3:0]        rl_eff;
    logic [3:0]        count4;
    logic              shift;
    logic              append;
    logic              prefix;
    logic              rep_last;
    logic [CAP-1:0]    match;
    logic [CAP-1:0]    active;
    logic [7:0]        cell_data [CAP];
    ostage_req_t       oreq;
    ostage_sts_t       osts;

    // ---------------------------------------------------------------
    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[3:0];
                CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    // Effective lengths: pattern 0 acts as 1, both saturate
    assign len_min1 = (pattern_length_reg == 4'd0) ? 4'd1 : pattern_length_reg;
    assign len_eff  = (len_min1 > CAP4) ? CAP4 : len_min1;
    assign rl_eff   = (replacement_length_reg > RMAX) ? RMAX : replacement_length_reg;
    assign count4   = 4'(count_reg);

    // ---------------------------------------------------------------
    // Pending row of cells; cell 0 holds the oldest byte
    assign append = (state_reg == S_IDLE) && in_tvalid && in_tready;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [7:0] next_byte;

        if (i == CAP - 1)
        begin : g_tail
            assign next_byte = 8'h00;
        end
        else
        begin : g_mid
            assign next_byte = cell_data[i+1];
        end

        assign active[i] = (count_reg > CNT_W'(i));

        ssr_cell u_cell
        (
            .clk       (clk),
            .shift     (shift),
            .load      (append && (count_reg == CNT_W'(i))),
            .load_byte (in_tdata),
            .next_byte (next_byte),
            .pat_byte  (pattern_bytes_reg[8*i +: 8]),
            .data      (cell_data[i]),
            .match     (match[i])
        );
    end

    // Pending bytes still a prefix of the pattern
    assign prefix = (count4 <= len_eff) && (&(match | ~active));

    assign rep_last = ((4'(rep_idx_reg) + 4'd1) == rl_eff);

    // ---------------------------------------------------------------
    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rep_idx_next = rep_idx_reg;
        eos_next     = eos_reg;
        shift        = 1'b0;
        oreq.emit    = 1'b0;
        oreq.close   = 1'b0;
        oreq.data    = cell_data[0];
        case (state_reg)
            S_IDLE:
            begin
                if (append)
                begin
                    count_next = count_reg + 1'b1;
                    eos_next   = in_tlast;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((count_reg != '0) && !prefix)
                begin
                    // oldest byte can no longer start a match
                    oreq.emit = 1'b1;
                    if (osts.emit_ok)
                    begin
                        shift      = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                else if (count4 == len_eff)
                begin
                    count_next   = '0;
                    rep_idx_next = '0;
                    state_next   = (rl_eff == 4'd0) ? S_DONE : S_REPL;
                end
                else if (eos_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REPL:
            begin
                oreq.emit = 1'b1;
                oreq.data = replacement_bytes_reg[8*rep_idx_reg +: 8];
                if (osts.emit_ok)
                begin
                    rep_idx_next = rep_idx_reg + 3'd1;
                    if (rep_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (count_reg != '0)
                begin
                    oreq.emit = 1'b1;
                    if (osts.emit_ok)
                    begin
                        shift      = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // last held byte goes out marked as end of run
                oreq.close = 1'b1;
                if (osts.close_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_idx_reg <= rep_idx_next;
        eos_reg     <= eos_next;
    end

    assign in_tready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------
    // Output stage
    ssr_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (oreq),
        .sts        (osts),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata),
        .out_tlast  (out_tlast)
    );

endmodule

`default_nettype wire

>>> sv/ssr_checker.sv
// Port-level checks for stream_search_and_replace, bound to the top level.
// Depends on ssr_pkg for the config index width.
`default_nettype none

module ssr_checker
    import ssr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_tvalid,
    input  wire logic                     in_tready,
    input  wire logic                     out_tvalid,
    input  wire logic                     out_tready,
    input  wire logic               [7:0] out_tdata,
    input  wire logic                     out_tlast,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [SSR_CFG_IDX_W-1:0] cfg_index
);

    // A stalled output beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
        else $error("output beat changed while stalled");

    // An accepted input beat keeps the sequencer busy, holding in_tready low
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
        else $error("input taken again too early");

    // Config writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled at index %0d", cfg_index);

endmodule

bind stream_search_and_replace ssr_checker u_ssr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index)
);

`default_nettype wire
